// File: rtl/mrc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request checker.
// Depends on nothing; every module of the block imports it.
package mrc_pkg;

  // Frame limits and byte counter.
  localparam int MAX_FRAME_BYTES = 256;
  localparam int CNT_W           = 9;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;
  localparam logic [CNT_W-1:0] MIN_FRAME_BYTES = CNT_W'(4);

  // CRC-16 constants, reflected form.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUANTITY = 1'b1;
  localparam logic [7:0]  SLAVE_ID_RESET     = 8'd1;
  localparam logic [15:0] MAX_QUANTITY_RESET = 16'd256;
  localparam logic [7:0]  BROADCAST_ID       = 8'd0;

  // Function codes.
  localparam logic [7:0] FC_READ_COIL_STATUS = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS      = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING     = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_REGS  = 8'd4;
  localparam logic [7:0] FC_WRITE_ONE_COIL   = 8'd5;
  localparam logic [7:0] FC_WRITE_REG        = 8'd6;
  localparam logic [7:0] FC_WRITE_MANY_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS       = 8'd16;

  // Response lengths that do not depend on the quantity.
  localparam logic [15:0] RESP_WRITE     = 16'd8;
  localparam logic [15:0] RESP_EXCEPTION = 16'd5;
  localparam logic [15:0] RESP_NONE      = 16'd0;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK               = 2'd0,
    ST_ILLEGAL_FUNCTION = 2'd1,
    ST_ILLEGAL_ADDRESS  = 2'd2
  } status_t;

  // Summary of one frame that passed the length and CRC checks.
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [7:0]       station;
    logic [7:0]       code;
    logic [15:0]      address;
    logic [15:0]      qty;
  } frame_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/modbus_rtu_request_checker.sv
`timescale 1ns / 1ps
// Top level of the Modbus RTU request checker: configuration registers and
// the front, queue and back parts. Uses mrc_pkg, mrc_front, mrc_queue, mrc_back.
//
//   Channel  Handshake              Words
//   input    in_valid / in_ready    rx_byte, frame_end (one request byte)
//   output   out_valid / out_ready  status .. response_length (one descriptor)
//   config   cfg_write_en           cfg_index, cfg_data
//
// One byte is taken every cycle while the queue is not full; a byte enters the
// CRC as it leaves the two-byte delay line. With the queue empty and the output
// register free, a kept frame's summary is written to the queue, then out_valid is set.
// Reset clears the frame state and the queue and loads slave_id 1, max_quantity 256.
// The front stalls only when the two-entry summary queue is full; the back
// stalls only on out_ready.
module modbus_rtu_request_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [1:0]  status,
  output logic [7:0]  function_code,
  output logic [15:0] start_address,
  output logic [15:0] quantity,
  output logic        is_broadcast,
  output logic [15:0] response_length,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_write_en,
  input  logic [mrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import mrc_pkg::*;

  logic [7:0]  slave_id;
  logic [15:0] max_quantity;
  logic        push;
  frame_t      push_frame;
  logic        pop;
  logic        queue_full;
  logic        queue_valid;
  frame_t      head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id     <= SLAVE_ID_RESET;
      max_quantity <= MAX_QUANTITY_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SLAVE_ID:     slave_id     <= cfg_data[7:0];
        CFG_MAX_QUANTITY: max_quantity <= cfg_data;
      endcase
    end
  end

  mrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .frame_end  (frame_end),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .queue_full (queue_full),
    .push       (push),
    .push_frame (push_frame)
  );

  mrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_valid),
    .head       (head)
  );

  mrc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .slave_id        (slave_id),
    .max_quantity    (max_quantity),
    .queue_valid     (queue_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .function_code   (function_code),
    .start_address   (start_address),
    .quantity        (quantity),
    .is_broadcast    (is_broadcast),
    .response_length (response_length)
  );

endmodule

// File: rtl/mrc_front.sv
`timescale 1ns / 1ps
// Front part: takes request bytes, runs the CRC, captures header fields and
// pushes a frame summary when a frame ends with a good length and CRC. Uses mrc_pkg.
module mrc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic            frame_end,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            queue_full,
  output logic            push,
  output mrc_pkg::frame_t push_frame
);
  import mrc_pkg::*;

  logic [15:0]      crc, crc_next;
  logic [15:0]      delay, delay_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       station, station_next;
  logic [7:0]       code, code_next;
  logic [15:0]      address, address_next;
  logic [15:0]      qty, qty_next;
  logic             accept;
  logic             frame_ok;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Per-word update of the running frame state.
  always_comb begin
    crc_next     = (count >= CNT_W'(2)) ? crc_feed(crc, delay[15:8]) : crc;
    delay_next   = {delay[7:0], rx_byte};
    count_next   = (count == COUNT_LIMIT) ? count : count + CNT_W'(1);
    station_next = station;
    code_next    = code;
    address_next = address;
    qty_next     = qty;
    unique case (count)
      CNT_W'(0): station_next = rx_byte;
      CNT_W'(1): code_next    = rx_byte;
      CNT_W'(2): address_next = {rx_byte, address[7:0]};
      CNT_W'(3): address_next = {address[15:8], rx_byte};
      CNT_W'(4): qty_next     = {rx_byte, qty[7:0]};
      CNT_W'(5): qty_next     = {qty[15:8], rx_byte};
      default: ;
    endcase
  end

  // Length and CRC checks; the received CRC is sent low byte first.
  assign frame_ok = (count_next >= MIN_FRAME_BYTES)
                 && (count_next <= CNT_W'(MAX_FRAME_BYTES))
                 && (crc_next == {delay_next[7:0], delay_next[15:8]});

  assign push = accept && frame_end && frame_ok;
  always_comb begin
    push_frame.len     = count_next;
    push_frame.station = station_next;
    push_frame.code    = code_next;
    push_frame.address = address_next;
    push_frame.qty     = qty_next;
  end

  // Frame state: cleared on reset and after every frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_SEED;
      delay   <= '0;
      count   <= '0;
      station <= '0;
      code    <= '0;
      address <= '0;
      qty     <= '0;
    end else if (accept) begin
      if (frame_end) begin
        crc     <= CRC_SEED;
        delay   <= '0;
        count   <= '0;
        station <= '0;
        code    <= '0;
        address <= '0;
        qty     <= '0;
      end else begin
        crc     <= crc_next;
        delay   <= delay_next;
        count   <= count_next;
        station <= station_next;
        code    <= code_next;
        address <= address_next;
        qty     <= qty_next;
      end
    end
  end

endmodule

// File: rtl/mrc_queue.sv
`timescale 1ns / 1ps
// Short queue of frame summaries between the front and the back.
// Uses frame_t and the queue depth from mrc_pkg.
module mrc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrc_pkg::frame_t push_frame,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output mrc_pkg::frame_t head
);
  import mrc_pkg::*;

  frame_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  // Storage is written only at the write pointer.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/mrc_back.sv
`timescale 1ns / 1ps
// Back part: address filter, short-write drop, status and response length,
// and the output register. Uses mrc_pkg.
module mrc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        slave_id,
  input  logic [15:0]       max_quantity,
  input  logic              queue_valid,
  input  mrc_pkg::frame_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [7:0]        function_code,
  output logic [15:0]       start_address,
  output logic [15:0]       quantity,
  output logic              is_broadcast,
  output logic [15:0]       response_length
);
  import mrc_pkg::*;

  logic        bcast;
  logic        addr_ok;
  logic        qbad;
  logic [16:0] coil_bytes;
  logic [16:0] coil_resp;
  logic [17:0] reg_resp;
  logic [17:0] len_ext;
  logic        short_coils;
  logic        short_regs;
  logic        keep;
  status_t     st;
  logic [15:0] resp;

  assign bcast   = (head.station == BROADCAST_ID);
  assign addr_ok = (head.station == slave_id) || bcast;
  assign qbad    = (head.qty > max_quantity);

  // Quantity-dependent lengths.
  assign coil_bytes  = ({1'b0, head.qty} + 17'd7) >> 3;
  assign coil_resp   = coil_bytes + 17'd5;
  assign reg_resp    = {1'b0, head.qty, 1'b0} + 18'd5;
  assign len_ext     = 18'(head.len);
  assign short_coils = len_ext < ({1'b0, coil_bytes} + 18'd9);
  assign short_regs  = len_ext < ({1'b0, head.qty, 1'b0} + 18'd9);

  // Classification by function code.
  always_comb begin
    st   = ST_OK;
    resp = RESP_NONE;
    keep = addr_ok;
    unique case (head.code)
      FC_READ_COIL_STATUS, FC_READ_INPUTS: begin
        st   = qbad ? ST_ILLEGAL_ADDRESS : ST_OK;
        resp = coil_resp[15:0];
      end
      FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
        st   = qbad ? ST_ILLEGAL_ADDRESS : ST_OK;
        resp = (reg_resp > 18'h0FFFF) ? 16'hFFFF : reg_resp[15:0];
      end
      FC_WRITE_ONE_COIL, FC_WRITE_REG: begin
        resp = RESP_WRITE;
      end
      FC_WRITE_MANY_COILS: begin
        keep = addr_ok && !short_coils;
        st   = qbad ? ST_ILLEGAL_ADDRESS : ST_OK;
        resp = RESP_WRITE;
      end
      FC_WRITE_REGS: begin
        keep = addr_ok && !short_regs;
        st   = qbad ? ST_ILLEGAL_ADDRESS : ST_OK;
        resp = RESP_WRITE;
      end
      default: begin
        st = ST_ILLEGAL_FUNCTION;
      end
    endcase
    if (st != ST_OK) begin
      resp = bcast ? RESP_NONE : RESP_EXCEPTION;
    end
  end

  // A summary leaves the queue whenever the output register can take it.
  assign pop = queue_valid && (!out_valid || out_ready);

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= keep;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop && keep) begin
      status          <= st;
      function_code   <= head.code;
      start_address   <= head.address;
      quantity        <= head.qty;
      is_broadcast    <= bcast;
      response_length <= resp;
    end
  end

endmodule
